FILE: hdl/klt_pkg.sv
// keyed lock table package: status codes, request token type and sizing defaults
// used by klt_cell and keyed_lock_table; depends on nothing else
`default_nettype none

package klt_pkg;

    localparam int unsigned TABLE_ENTRIES_DEF = 16;

    localparam int unsigned CLIENT_W = 16;
    localparam int unsigned KEY_W    = 64;
    localparam int unsigned COUNT_W  = 32;

    localparam logic [COUNT_W-1:0] GRANT_MAX = {COUNT_W{1'b1}};

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_BUSY      = 2'd1,
        ST_NOT_OWNER = 2'd2,
        ST_FULL      = 2'd3
    } status_t;

    typedef enum logic {
        ACT_ACQUIRE = 1'b0,
        ACT_RELEASE = 1'b1
    } action_t;

    // request walking down the chain, with its answer once a cell has taken it
    typedef struct packed {
        action_t               action;
        logic [CLIENT_W-1:0]   client;
        logic [KEY_W-1:0]      key;
        logic                  done;
        status_t               status;
        logic [COUNT_W-1:0]    count;
    } token_t;

endpackage

`default_nettype wire

FILE: hdl/klt_cell.sv
// one lock table entry with its slot of the request chain
// depends on klt_pkg (token type, status codes, field widths)
`default_nettype none

module klt_cell (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            adv,
    input  wire logic            tok_in_vld,
    input  wire klt_pkg::token_t tok_in,
    output logic                 tok_out_vld,
    output klt_pkg::token_t      tok_out
);

    logic                          valid_reg, valid_next;
    logic                          held_reg, held_next;
    logic [klt_pkg::KEY_W-1:0]     key_reg, key_next;
    logic [klt_pkg::CLIENT_W-1:0]  owner_reg, owner_next;
    logic [klt_pkg::COUNT_W-1:0]   grants_reg, grants_next;
    logic                          tok_vld_reg;
    klt_pkg::token_t               tok_reg, tok_next;
    logic                          live;
    logic                          hit;
    logic [klt_pkg::COUNT_W-1:0]   grants_inc;

    assign live       = tok_in_vld && !tok_in.done;
    assign hit        = valid_reg && (key_reg == tok_in.key);
    assign grants_inc = (grants_reg == klt_pkg::GRANT_MAX) ? grants_reg
                                                           : grants_reg + 1'b1;

    always_comb
    begin
        valid_next  = valid_reg;
        held_next   = held_reg;
        key_next    = key_reg;
        owner_next  = owner_reg;
        grants_next = grants_reg;
        tok_next    = tok_in;
        if (live && hit)
        begin
            tok_next.done = 1'b1;
            if (tok_in.action == klt_pkg::ACT_ACQUIRE)
            begin
                if (held_reg)
                begin
                    tok_next.status = klt_pkg::ST_BUSY;
                    tok_next.count  = grants_reg;
                end
                else
                begin
                    held_next       = 1'b1;
                    owner_next      = tok_in.client;
                    grants_next     = grants_inc;
                    tok_next.status = klt_pkg::ST_OK;
                    tok_next.count  = grants_inc;
                end
            end
            else
            begin
                tok_next.count = grants_reg;
                if (held_reg && (owner_reg == tok_in.client))
                begin
                    held_next       = 1'b0;
                    tok_next.status = klt_pkg::ST_OK;
                end
                else
                begin
                    tok_next.status = klt_pkg::ST_NOT_OWNER;
                end
            end
        end
        else if (live && !valid_reg)
        begin
            // first free entry: allocated entries form a prefix, so the key is unknown
            tok_next.done = 1'b1;
            if (tok_in.action == klt_pkg::ACT_ACQUIRE)
            begin
                valid_next      = 1'b1;
                held_next       = 1'b1;
                key_next        = tok_in.key;
                owner_next      = tok_in.client;
                grants_next     = {{(klt_pkg::COUNT_W-1){1'b0}}, 1'b1};
                tok_next.status = klt_pkg::ST_OK;
                tok_next.count  = {{(klt_pkg::COUNT_W-1){1'b0}}, 1'b1};
            end
            else
            begin
                tok_next.status = klt_pkg::ST_NOT_OWNER;
                tok_next.count  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg   <= 1'b0;
            held_reg    <= 1'b0;
            tok_vld_reg <= 1'b0;
        end
        else if (adv)
        begin
            valid_reg   <= valid_next;
            held_reg    <= held_next;
            tok_vld_reg <= tok_in_vld;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            key_reg    <= key_next;
            owner_reg  <= owner_next;
            grants_reg <= grants_next;
            tok_reg    <= tok_next;
        end
    end

    assign tok_out_vld = tok_vld_reg;
    assign tok_out     = tok_reg;

endmodule

`default_nettype wire

FILE: hdl/keyed_lock_table.sv
// keyed lock table top level: request entry, chain of entry cells, result register
// depends on klt_pkg and klt_cell
//
//   channel   direction  handshake             fields
//   request   in         in_valid / in_stall   action, client_id, lock_id
//   result    out        out_valid / out_stall status, grant_count
//
// a request walks the chain one cell per cycle while the chain is not held, then
// lands in the result register; one request is in the chain at a time, so a new
// request is not taken until the last answer has moved into the result register
// reset clears the valid and held bits of every entry at once; no clearing pass
// a new request is taken while a result still waits in the output register; a
// stalled result freezes the chain only when the next result reaches its end
`default_nettype none

module keyed_lock_table #(
    parameter int unsigned TABLE_ENTRIES = klt_pkg::TABLE_ENTRIES_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         in_valid,
    output logic                              in_stall,
    input  wire logic                         action,
    input  wire logic [klt_pkg::CLIENT_W-1:0] client_id,
    input  wire logic [klt_pkg::KEY_W-1:0]    lock_id,
    output logic                              out_valid,
    input  wire logic                         out_stall,
    output logic [1:0]                        status,
    output logic [klt_pkg::COUNT_W-1:0]       grant_count
);

    // tok_vld[i] / tok[i] feed cell i; index TABLE_ENTRIES is the chain tail
    logic                  tok_vld [TABLE_ENTRIES+1];
    klt_pkg::token_t       tok     [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] cell_vld_vec;

    logic                  accept;
    logic                  tail_load;
    logic                  adv;
    logic                  busy_reg, busy_next;
    logic                  out_valid_reg, out_valid_next;
    klt_pkg::status_t      out_status_reg;
    logic [klt_pkg::COUNT_W-1:0] out_count_reg;

    assign in_stall  = busy_reg;
    assign accept    = in_valid && !busy_reg;

    // result register takes the tail when empty or being drained
    assign tail_load = tok_vld[TABLE_ENTRIES] && (!out_valid_reg || !out_stall);
    // hold the whole chain while the tail waits for the result register
    assign adv       = !(tok_vld[TABLE_ENTRIES] && !tail_load);

    // a fresh request defaults to the answer it gets when no cell takes it
    always_comb
    begin
        tok_vld[0]       = accept;
        tok[0].action    = klt_pkg::action_t'(action);
        tok[0].client    = client_id;
        tok[0].key       = lock_id;
        tok[0].done      = 1'b0;
        tok[0].status    = (action == klt_pkg::ACT_RELEASE) ? klt_pkg::ST_NOT_OWNER
                                                            : klt_pkg::ST_FULL;
        tok[0].count     = '0;
    end

    for (genvar gi = 0; gi < TABLE_ENTRIES; gi++)
    begin : g_cell
        klt_cell u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .adv         (adv),
            .tok_in_vld  (tok_vld[gi]),
            .tok_in      (tok[gi]),
            .tok_out_vld (tok_vld[gi+1]),
            .tok_out     (tok[gi+1])
        );
        assign cell_vld_vec[gi] = tok_vld[gi+1];
    end

    // busy from request transfer until its answer moves into the result register
    always_comb
    begin
        busy_next = busy_reg;
        if (accept)
        begin
            busy_next = 1'b1;
        end
        else if (tail_load)
        begin
            busy_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (tail_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            busy_reg      <= busy_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (tail_load)
        begin
            out_status_reg <= tok[TABLE_ENTRIES].status;
            out_count_reg  <= tok[TABLE_ENTRIES].count;
        end
    end

    assign out_valid   = out_valid_reg;
    assign status      = out_status_reg;
    assign grant_count = out_count_reg;

`ifndef SYNTHESIS
    // at most one request in the chain at any time
    a_one_token: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot0(cell_vld_vec))
        else $error("more than one request in the cell chain");

    // an idle block has an empty chain
    a_idle_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !busy_reg |-> (cell_vld_vec == '0))
        else $error("request in chain while not busy");

    // a request transfer makes the block busy
    a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> busy_reg)
        else $error("request accepted but block not busy");

    // a new result only appears after a request left the chain tail
    a_result_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(tok_vld[TABLE_ENTRIES]))
        else $error("result without a request at the chain tail");
`endif

endmodule

`default_nettype wire

FILE: tb/keyed_lock_table_tb.sv
// testbench for keyed_lock_table: directed request table, then random lock traffic
// checked against an in-bench lock table predictor; depends on klt_pkg and the rtl
`timescale 1ns / 1ps

module keyed_lock_table_tb;

    localparam int unsigned N_ENTRIES   = klt_pkg::TABLE_ENTRIES_DEF;
    localparam int          N_RANDOM    = 1130;
    localparam int          CYCLE_LIMIT = 500000;
    // long enough for the chain to drain twice over
    localparam int          DRAIN_WAIT  = 2 * (N_ENTRIES + 1) + 8;
    localparam int          HOLD_CYCLES = 300;
    localparam int          N_DIRECTED  = 24;

    // one expected answer per accepted request
    typedef struct {
        klt_pkg::status_t              st;
        logic [klt_pkg::COUNT_W-1:0]   cnt;
    } answer_t;

    // one row of the directed table; typed rows carry their answer
    typedef struct {
        klt_pkg::action_t              act;
        logic [klt_pkg::CLIENT_W-1:0]  cli;
        logic [klt_pkg::KEY_W-1:0]     key;
        bit                            typed;
        klt_pkg::status_t              st;
        logic [klt_pkg::COUNT_W-1:0]   cnt;
    } req_row_t;

    logic                          clk;
    logic                          rst_n;
    logic                          in_valid;
    logic                          in_stall;
    klt_pkg::action_t              action;
    logic [klt_pkg::CLIENT_W-1:0]  client_id;
    logic [klt_pkg::KEY_W-1:0]     lock_id;
    logic                          out_valid;
    logic                          out_stall;
    logic [1:0]                    status;
    logic [klt_pkg::COUNT_W-1:0]   grant_count;

    // predictor copy of the lock table
    bit                            ent_valid  [N_ENTRIES];
    logic [klt_pkg::KEY_W-1:0]     ent_key    [N_ENTRIES];
    bit                            ent_held   [N_ENTRIES];
    logic [klt_pkg::CLIENT_W-1:0]  ent_owner  [N_ENTRIES];
    logic [klt_pkg::COUNT_W-1:0]   ent_grants [N_ENTRIES];

    answer_t              pending_answers [$];
    int                   mismatch_cnt;
    int                   cycle_cnt;
    bit                   calm;       // no idling on either side while set
    bit                   hold_rx;    // asks the receiver for a long hold-off

    keyed_lock_table u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .client_id   (client_id),
        .lock_id     (lock_id),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .status      (status),
        .grant_count (grant_count)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    task automatic flag_mismatch(input string msg);
        mismatch_cnt++;
        // keep the log bounded when the block is badly off
        if (mismatch_cnt <= 200)
        begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endtask

    // answer to one request, updating the predictor's table
    function automatic void predict_lock_answer(input klt_pkg::action_t act,
                                                input logic [klt_pkg::CLIENT_W-1:0] cli,
                                                input logic [klt_pkg::KEY_W-1:0] key,
                                                output answer_t ans);
        int hit;
        int slot;
        hit  = -1;
        slot = -1;
        // lowest matching entry and lowest free entry
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            if (hit < 0 && ent_valid[i] && ent_key[i] == key)
                hit = i;
            if (slot < 0 && !ent_valid[i])
                slot = i;
        end
        ans.cnt = '0;
        if (act == klt_pkg::ACT_ACQUIRE)
        begin
            if (hit < 0)
            begin
                if (slot < 0)
                begin
                    ans.st = klt_pkg::ST_FULL;
                end
                else
                begin
                    ent_valid[slot]  = 1'b1;
                    ent_key[slot]    = key;
                    ent_held[slot]   = 1'b1;
                    ent_owner[slot]  = cli;
                    ent_grants[slot] = 32'd1;
                    ans.st  = klt_pkg::ST_OK;
                    ans.cnt = 32'd1;
                end
            end
            else if (ent_held[hit])
            begin
                ans.st  = klt_pkg::ST_BUSY;
                ans.cnt = ent_grants[hit];
            end
            else
            begin
                ent_held[hit]  = 1'b1;
                ent_owner[hit] = cli;
                if (ent_grants[hit] != klt_pkg::GRANT_MAX)
                    ent_grants[hit] = ent_grants[hit] + 32'd1;
                ans.st  = klt_pkg::ST_OK;
                ans.cnt = ent_grants[hit];
            end
        end
        else
        begin
            if (hit < 0)
            begin
                ans.st = klt_pkg::ST_NOT_OWNER;
            end
            else if (ent_held[hit] && ent_owner[hit] == cli)
            begin
                ent_held[hit] = 1'b0;
                ans.st  = klt_pkg::ST_OK;
                ans.cnt = ent_grants[hit];
            end
            else
            begin
                ans.st  = klt_pkg::ST_NOT_OWNER;
                ans.cnt = ent_grants[hit];
            end
        end
    endfunction

    // offer one request from a falling edge, return at the falling edge after transfer
    task automatic send_request(input klt_pkg::action_t act,
                                input logic [klt_pkg::CLIENT_W-1:0] cli,
                                input logic [klt_pkg::KEY_W-1:0] key, input bit typed,
                                input klt_pkg::status_t st,
                                input logic [klt_pkg::COUNT_W-1:0] cnt);
        answer_t ans;
        // random gaps before the request
        while (!calm && $urandom_range(99) < 36)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid  <= 1'b1;
        action    <= act;
        client_id <= cli;
        lock_id   <= key;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // transfer taken at this edge: predict now, in order of acceptance
        predict_lock_answer(act, cli, key, ans);
        if (typed)
        begin
            ans.st  = st;
            ans.cnt = cnt;
        end
        pending_answers.push_back(ans);
        @(negedge clk);
    endtask

    // receiver: random stalls, plus one long hold-off counted here
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            if (hold_rx)
            begin
                repeat (HOLD_CYCLES)
                begin
                    out_stall <= 1'b1;
                    @(negedge clk);
                end
                hold_rx = 1'b0;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(99) < 36);
                @(negedge clk);
            end
        end
    end

    // result checker: every transfer against the oldest expectation
    always @(posedge clk)
    begin
        answer_t ans;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_answers.size() == 0)
            begin
                flag_mismatch($sformatf("unexpected result status %0d count %0d",
                                        status, grant_count));
            end
            else
            begin
                ans = pending_answers.pop_front();
                if (status !== ans.st)
                    flag_mismatch($sformatf("status %0d, expected %0d", status, ans.st));
                if (grant_count !== ans.cnt)
                    flag_mismatch($sformatf("grant_count %0d, expected %0d",
                                            grant_count, ans.cnt));
            end
        end
    end

    // watchdog
    initial
    begin
        cycle_cnt = 0;
        while (cycle_cnt < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_cnt++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        req_row_t                      dir_rows [N_DIRECTED];
        int                            r;
        int                            idx;
        klt_pkg::action_t              act;
        logic [klt_pkg::CLIENT_W-1:0]  cli;
        logic [klt_pkg::KEY_W-1:0]     key;

        rst_n        = 1'b0;
        in_valid     = 1'b0;
        action       = klt_pkg::ACT_ACQUIRE;
        client_id    = '0;
        lock_id      = '0;
        calm         = 1'b0;
        hold_rx      = 1'b0;
        mismatch_cnt = 0;
        for (int i = 0; i < N_ENTRIES; i++)
        begin
            ent_valid[i]  = 1'b0;
            ent_held[i]   = 1'b0;
            ent_key[i]    = '0;
            ent_owner[i]  = '0;
            ent_grants[i] = '0;
        end

        // directed table: one lock through its cases, all-ones key, then fill to full
        dir_rows[0] = '{klt_pkg::ACT_ACQUIRE, 16'h0000, 64'h0, 1'b1,
                        klt_pkg::ST_OK, 32'd1};
        // busy for another client and for the holder itself
        dir_rows[1] = '{klt_pkg::ACT_ACQUIRE, 16'h0001, 64'h0, 1'b1,
                        klt_pkg::ST_BUSY, 32'd1};
        dir_rows[2] = '{klt_pkg::ACT_ACQUIRE, 16'h0000, 64'h0, 1'b1,
                        klt_pkg::ST_BUSY, 32'd1};
        // release by a non-holder, by the holder, then of a free lock
        dir_rows[3] = '{klt_pkg::ACT_RELEASE, 16'h0001, 64'h0, 1'b1,
                        klt_pkg::ST_NOT_OWNER, 32'd1};
        dir_rows[4] = '{klt_pkg::ACT_RELEASE, 16'h0000, 64'h0, 1'b1,
                        klt_pkg::ST_OK, 32'd1};
        dir_rows[5] = '{klt_pkg::ACT_RELEASE, 16'h0000, 64'h0, 1'b1,
                        klt_pkg::ST_NOT_OWNER, 32'd1};
        // re-grant of a known free lock, count from the predictor
        dir_rows[6] = '{klt_pkg::ACT_ACQUIRE, 16'hffff, 64'h0, 1'b0,
                        klt_pkg::ST_OK, 32'd0};
        // release of an unknown id, then allocate the all-ones key
        dir_rows[7] = '{klt_pkg::ACT_RELEASE, 16'hffff, {klt_pkg::KEY_W{1'b1}}, 1'b1,
                        klt_pkg::ST_NOT_OWNER, 32'd0};
        dir_rows[8] = '{klt_pkg::ACT_ACQUIRE, 16'hffff, {klt_pkg::KEY_W{1'b1}}, 1'b1,
                        klt_pkg::ST_OK, 32'd1};
        for (int i = 9; i < N_DIRECTED - 1; i++)
        begin
            dir_rows[i] = '{klt_pkg::ACT_ACQUIRE, 16'($urandom), {$urandom, $urandom},
                            1'b1, klt_pkg::ST_OK, 32'd1};
        end
        // table now full: an unknown id is refused
        dir_rows[N_DIRECTED-1] = '{klt_pkg::ACT_ACQUIRE, 16'h1234,
                                   64'h8000_0000_0000_0001,
                                   1'b1, klt_pkg::ST_FULL, 32'd0};

        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int i = 0; i < N_DIRECTED; i++)
        begin
            send_request(dir_rows[i].act, dir_rows[i].cli, dir_rows[i].key,
                         dir_rows[i].typed, dir_rows[i].st, dir_rows[i].cnt);
        end

        // random traffic: mostly keys already in the table, some unknown ids
        for (int n = 0; n < N_RANDOM; n++)
        begin
            if (n == 300)
                hold_rx = 1'b1;
            calm = (n >= 600 && n < 800);
            r   = $urandom_range(99);
            act = klt_pkg::action_t'($urandom_range(1));
            if (r < 12)
            begin
                key = {$urandom, $urandom};
                cli = 16'($urandom);
            end
            else
            begin
                idx = $urandom_range(N_ENTRIES - 1);
                key = ent_key[idx];
                // releases often come from the holder so locks cycle
                if (act == klt_pkg::ACT_RELEASE && ent_held[idx] && $urandom_range(1))
                    cli = ent_owner[idx];
                else if ($urandom_range(4) == 0)
                    cli = 16'($urandom);
                else
                    cli = 16'($urandom_range(3));
            end
            send_request(act, cli, key, 1'b0, klt_pkg::ST_OK, '0);
        end
        calm = 1'b0;
        in_valid <= 1'b0;

        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_cnt == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

FILE: keyed_lock_table.f
hdl/klt_pkg.sv
hdl/klt_cell.sv
hdl/keyed_lock_table.sv
tb/keyed_lock_table_tb.sv
